// ===== sv/tgcl_pkg.sv =====
// tgcl_pkg: shared constants, codes and lookup functions for the glyph cursor layout
// no dependencies; used by text_glyph_cursor_layout and tgcl_checker
`timescale 1ns / 1ps

package tgcl_pkg;

  localparam int CoordW      = 16;
  localparam int CharW       = 8;
  localparam int CfgIndexW   = 2;
  localparam int CfgDataW    = 5;
  localparam int LineAdvance = 16;
  // tab stop must be a power of two
  localparam int TabStop     = 32;
  localparam int TabShift    = $clog2(TabStop);
  localparam int MonoAdvance = 8;

  // opcode in tuser
  localparam logic OpBegin = 1'b0;
  localparam logic OpChar  = 1'b1;

  // control characters
  localparam logic [CharW-1:0] CharTab     = 8'd9;
  localparam logic [CharW-1:0] CharNewline = 8'd10;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgMonospace     = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgKernEnable    = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgLetterSpacing = 2'd2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoordW+1:0] coord_wide_t;

  // advance widths for codes 32..127
  localparam logic [3:0] WidthTable [96] = '{
    4'd4, 4'd2, 4'd4, 4'd8, 4'd6, 4'd8, 4'd6, 4'd2, 4'd4, 4'd4, 4'd6, 4'd8, 4'd4, 4'd8, 4'd2, 4'd8,
    4'd6, 4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd2, 4'd4, 4'd6, 4'd8, 4'd6, 4'd6, 4'd8,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd2, 4'd6, 4'd6, 4'd6, 4'd8,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd8, 4'd6, 4'd6, 4'd6,
    4'd4, 4'd8, 4'd4, 4'd6, 4'd8, 4'd2,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd6, 4'd6, 4'd2, 4'd4, 4'd6, 4'd4, 4'd8,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd6, 4'd4, 4'd6, 4'd6, 4'd8, 4'd6, 4'd6, 4'd6,
    4'd4, 4'd2, 4'd4, 4'd6,
    4'd0
  };

  function automatic logic is_drawable(input logic [CharW-1:0] code);
    is_drawable = (code >= 8'd32 && code <= 8'd127) || (code >= 8'd160);
  endfunction

  // advance before letter spacing
  function automatic logic [3:0] glyph_width(input logic [CharW-1:0] code,
                                             input logic         mono);
    logic [6:0] idx;
    idx = 7'(code - 8'd32);
    if (mono || code < 8'd32 || code > 8'd127) begin
      glyph_width = 4'(MonoAdvance);
    end else begin
      glyph_width = WidthTable[idx];
    end
  endfunction

  // pair kerning in whole pixels, zero for pairs not listed
  function automatic logic signed [5:0] kern_adjust(input logic [CharW-1:0] left,
                                                    input logic [CharW-1:0] right);
    unique case ({left, right})
      "AV":    kern_adjust = -6'sd20;
      "AW":    kern_adjust = -6'sd16;
      "AY":    kern_adjust = -6'sd18;
      "VA":    kern_adjust = -6'sd16;
      "WA":    kern_adjust = -6'sd14;
      "YA":    kern_adjust = -6'sd18;
      "Ta":    kern_adjust = -6'sd8;
      "Te":    kern_adjust = -6'sd8;
      "To":    kern_adjust = -6'sd8;
      "ff":    kern_adjust = -6'sd8;
      "fi":    kern_adjust = -6'sd6;
      "fl":    kern_adjust = -6'sd6;
      "rn":    kern_adjust = -6'sd4;
      "ro":    kern_adjust = -6'sd4;
      "ra":    kern_adjust = -6'sd4;
      "PA":    kern_adjust = -6'sd12;
      "FA":    kern_adjust = -6'sd10;
      "LV":    kern_adjust = -6'sd14;
      "LY":    kern_adjust = -6'sd12;
      default: kern_adjust = 6'sd0;
    endcase
  endfunction

  // clamp to the 16-bit coordinate range
  function automatic coord_t sat16(input coord_wide_t v);
    if (v > 18'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[CoordW-1:0];
    end
  endfunction

endpackage

// ===== sv/text_glyph_cursor_layout.sv =====
// text_glyph_cursor_layout: places glyphs of a byte string, one byte per cycle unless stalled
// input register, then result register; a result stall holds the byte in the input register
// the cursor update is a table lookup and two saturating adds
// reset (rst_ni low, asynchronous): cursor, line start and previous character cleared,
// monospace on, kerning off, letter spacing 0, both pipeline registers empty
// depends on tgcl_pkg
`timescale 1ns / 1ps

module text_glyph_cursor_layout (
  input  logic        clk_i,
  input  logic        rst_ni,

  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // origin_x[15:0], origin_y[31:16], char_code[39:32]
  input  logic [0:0]  s_axis_tuser,   // opcode[0]

  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // glyph_x[15:0], glyph_y[31:16], glyph_code[39:32]
  output logic [0:0]  m_axis_tuser,   // draw[0]

  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  // configuration registers
  logic              monospace_q;
  logic              kern_en_q;
  logic signed [4:0] letter_spacing_q;

  // cursor state
  tgcl_pkg::coord_t  cursor_x_q, cursor_x_d;
  tgcl_pkg::coord_t  cursor_y_q, cursor_y_d;
  tgcl_pkg::coord_t  line_start_x_q, line_start_x_d;
  logic [7:0]        prev_char_q, prev_char_d;

  // input register
  logic              in_valid_q;
  logic              in_opcode_q;
  tgcl_pkg::coord_t  in_origin_x_q;
  tgcl_pkg::coord_t  in_origin_y_q;
  logic [7:0]        in_char_q;

  // result register
  logic              out_valid_q;
  tgcl_pkg::coord_t  out_x_q;
  tgcl_pkg::coord_t  out_y_q;
  logic [7:0]        out_code_q;
  logic              out_draw_q;

  // datapath
  logic              is_char;
  logic              is_newline;
  logic              is_tab;
  logic              emits;
  logic              out_free;
  logic              fire;
  logic signed [5:0] kern;
  tgcl_pkg::coord_t  x_kern;
  tgcl_pkg::coord_t  x_adv;
  tgcl_pkg::coord_t  x_tab;
  tgcl_pkg::coord_t  y_newline;
  tgcl_pkg::coord_wide_t step;
  tgcl_pkg::coord_wide_t tab_quot;
  logic              tab_round_up;
  logic [3:0]        width;

  // configuration is always taken, writes beyond the register list are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      monospace_q      <= 1'b1;
      kern_en_q        <= 1'b0;
      letter_spacing_q <= 5'sd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tgcl_pkg::CfgMonospace:     monospace_q      <= cfg_data_i[0];
        tgcl_pkg::CfgKernEnable:    kern_en_q        <= cfg_data_i[0];
        tgcl_pkg::CfgLetterSpacing: letter_spacing_q <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // item classification
  assign is_char    = (in_opcode_q == tgcl_pkg::OpChar);
  assign is_newline = is_char && (in_char_q == tgcl_pkg::CharNewline);
  assign is_tab     = is_char && (in_char_q == tgcl_pkg::CharTab);
  assign emits      = is_char && !is_newline && !is_tab;

  // an item that gives a result needs room in the result register
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && (!emits || out_free);
  assign s_axis_tready = !in_valid_q || fire;

  // kerning against the previous byte, zero means none
  assign kern   = (kern_en_q && prev_char_q != 8'd0)
                  ? tgcl_pkg::kern_adjust(prev_char_q, in_char_q) : 6'sd0;
  assign x_kern = tgcl_pkg::sat16(18'(cursor_x_q) + 18'(kern));

  // advance: glyph width plus letter spacing
  assign width = tgcl_pkg::glyph_width(in_char_q, monospace_q);
  assign step  = 18'(signed'({1'b0, width})) + 18'(letter_spacing_q);
  assign x_adv = tgcl_pkg::sat16(18'(x_kern) + step);

  // tab: quotient truncated toward zero, so negative values with a remainder round up
  assign tab_round_up = cursor_x_q[15] &&
                        ((cursor_x_q & 16'(tgcl_pkg::TabStop - 1)) != 16'sd0);
  assign tab_quot     = 18'(cursor_x_q >>> tgcl_pkg::TabShift) + 18'(tab_round_up);
  assign x_tab        = tgcl_pkg::sat16((tab_quot + 18'sd1) <<< tgcl_pkg::TabShift);

  // newline
  assign y_newline = tgcl_pkg::sat16(18'(cursor_y_q) + 18'(tgcl_pkg::LineAdvance));

  // next cursor state
  always_comb begin
    cursor_x_d     = cursor_x_q;
    cursor_y_d     = cursor_y_q;
    line_start_x_d = line_start_x_q;
    prev_char_d    = prev_char_q;
    if (fire) begin
      priority if (!is_char) begin
        cursor_x_d     = in_origin_x_q;
        cursor_y_d     = in_origin_y_q;
        line_start_x_d = in_origin_x_q;
        prev_char_d    = 8'd0;
      end else if (is_newline) begin
        cursor_x_d  = line_start_x_q;
        cursor_y_d  = y_newline;
        prev_char_d = 8'd0;
      end else if (is_tab) begin
        cursor_x_d  = x_tab;
        prev_char_d = 8'd0;
      end else begin
        cursor_x_d  = x_adv;
        prev_char_d = in_char_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q     <= '0;
      cursor_y_q     <= '0;
      line_start_x_q <= '0;
      prev_char_q    <= '0;
    end else begin
      cursor_x_q     <= cursor_x_d;
      cursor_y_q     <= cursor_y_d;
      line_start_x_q <= line_start_x_d;
      prev_char_q    <= prev_char_d;
    end
  end

  // input register, refilled in the same cycle it drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_opcode_q   <= s_axis_tuser[0];
      in_origin_x_q <= signed'(s_axis_tdata[15:0]);
      in_origin_y_q <= signed'(s_axis_tdata[31:16]);
      in_char_q     <= s_axis_tdata[39:32];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && emits) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emits) begin
      out_x_q    <= x_kern;
      out_y_q    <= cursor_y_q;
      out_code_q <= in_char_q;
      out_draw_q <= tgcl_pkg::is_drawable(in_char_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_code_q, out_y_q, out_x_q};
  assign m_axis_tuser  = out_draw_q;

endmodule

// ===== sv/tgcl_checker.sv =====
// tgcl_checker: port-level assertions for the glyph cursor layout, bound to the top level
// depends on text_glyph_cursor_layout result ports and tgcl_pkg
`timescale 1ns / 1ps

module tgcl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // no result while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // draw flag agrees with the glyph code
  a_draw_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[0] ==
      ((m_axis_tdata[39:32] >= 8'd32 && m_axis_tdata[39:32] <= 8'd127) ||
       m_axis_tdata[39:32] >= 8'd160))
    else $error("draw flag does not match glyph code");

  // tab and newline only move the cursor
  a_no_ctrl_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39:32] != tgcl_pkg::CharTab) &&
                      (m_axis_tdata[39:32] != tgcl_pkg::CharNewline))
    else $error("result emitted for tab or newline");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind text_glyph_cursor_layout tgcl_checker u_tgcl_checker (.*);
